### src/lsrs_pkg.sv
// Shared types and constants for the line sensor readout sequencer.
`timescale 1ns / 1ps

package lsrs_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned INDEX_W  = 8;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SI_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLK_HALF     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd2;

	// Register values after reset.
	localparam logic [15:0] SI_WIDTH_RST     = 16'd30;
	localparam logic [15:0] CLK_HALF_RST     = 16'd50;
	localparam logic [31:0] FRAME_PERIOD_RST = 32'd25900;

	// Start pulse phase of the frame.
	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_PENDING = 2'd1,
		PH_RUN     = 2'd2
	} lsrs_phase_t;

	typedef struct packed {
		logic [15:0] si_width;
		logic [15:0] clk_half;
		logic [31:0] frame_period;
	} lsrs_cfg_t;

	// Frame timing state, apart from the pulse counter whose width follows PIXELS.
	typedef struct packed {
		logic [31:0] now_us;
		lsrs_phase_t phase;
		logic        clk_high;
		logic [31:0] start_time;
		logic [31:0] rise_time;
		logic [31:0] fall_time;
		logic        si_level;
		logic        clk_level;
	} lsrs_state_t;

	typedef struct packed {
		logic                si_out;
		logic                clk_out;
		logic                sample_valid;
		logic [INDEX_W-1:0]  pixel_index;
		logic [SAMPLE_W-1:0] pixel_value;
	} lsrs_result_t;

endpackage

### src/line_sensor_readout_sequencer.sv
// Top level of the line sensor readout sequencer.
`timescale 1ns / 1ps
//
// Each input transfer is one tick of TICK_US microseconds carrying the current
// converter reading on adc_sample. The block advances its microsecond counter,
// drives the sensor start pulse and the sensor clock, and returns one result
// per tick: the pin levels si_out and clk_out after the tick, and, at the end
// of each clock high half, the captured sample with its pixel index (index 0
// is the dummy pulse). After PIXELS+1 pulses and frame_period microseconds from
// the start pulse, the frame restarts. A tick accepted at one edge shows its
// result on the output channel right after that edge. Throughput is one tick
// per cycle unless the receiver stalls; the tick logic is a single pass from
// the state registers to the result register. When the receiver stalls, the
// result register holds its value and in_stall is raised in the same cycle, so
// the block takes no new tick until the held transfer completes. The
// configuration port writes si_width, clk_half and frame_period by index; the
// user must use it only while the block is idle, which the block itself does
// not enforce. Reset puts the registers at their defaults (30, 50, 25900),
// clears the counter and leaves a frame start pending for the first tick.

module line_sensor_readout_sequencer #(
	parameter int unsigned PIXELS  = 128,
	parameter int unsigned TICK_US = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsrs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lsrs_pkg::SAMPLE_W-1:0]   adc_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            si_out,
	output logic                            clk_out,
	output logic                            sample_valid,
	output logic [lsrs_pkg::INDEX_W-1:0]    pixel_index,
	output logic [lsrs_pkg::SAMPLE_W-1:0]   pixel_value
);
	import lsrs_pkg::*;

	localparam int unsigned PCW = $clog2(PIXELS + 2);

	lsrs_cfg_t    cfg;
	lsrs_state_t  st_q;
	lsrs_state_t  st_nx;
	logic [PCW-1:0] pulse_count_q;
	logic [PCW-1:0] pulse_count_nx;
	lsrs_result_t res_nx;
	lsrs_result_t res_q;
	logic         accept;
	logic         full_stalled;

	lsrs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A tick is taken whenever the result register is free or drains this cycle.
	assign in_stall = full_stalled;
	assign accept   = in_valid & ~in_stall;

	lsrs_step #(
		.PIXELS  (PIXELS),
		.TICK_US (TICK_US),
		.PCW     (PCW)
	) u_step (
		.st             (st_q),
		.pulse_count    (pulse_count_q),
		.cfg            (cfg),
		.adc_sample     (adc_sample),
		.st_nx          (st_nx),
		.pulse_count_nx (pulse_count_nx),
		.res            (res_nx)
	);

	// Frame state advances only on an accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.now_us     <= '0;
			st_q.phase      <= PH_PENDING;
			st_q.clk_high   <= 1'b1;
			st_q.start_time <= '0;
			st_q.rise_time  <= '0;
			st_q.fall_time  <= '0;
			st_q.si_level   <= 1'b0;
			st_q.clk_level  <= 1'b0;
			pulse_count_q   <= '0;
		end else if (accept) begin
			st_q          <= st_nx;
			pulse_count_q <= pulse_count_nx;
		end
	end

	lsrs_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.res_in       (res_nx),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.res_out      (res_q),
		.full_stalled (full_stalled)
	);

	assign si_out       = res_q.si_out;
	assign clk_out      = res_q.clk_out;
	assign sample_valid = res_q.sample_valid;
	assign pixel_index  = res_q.pixel_index;
	assign pixel_value  = res_q.pixel_value;

endmodule

### src/lsrs_cfg_regs.sv
// Configuration register file for the readout sequencer.
`timescale 1ns / 1ps

module lsrs_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lsrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsrs_pkg::CFG_W-1:0]     cfg_data,
	output lsrs_pkg::lsrs_cfg_t           cfg
);
	import lsrs_pkg::*;

	lsrs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.si_width     <= SI_WIDTH_RST;
			cfg_q.clk_half     <= CLK_HALF_RST;
			cfg_q.frame_period <= FRAME_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SI_WIDTH:     cfg_q.si_width     <= cfg_data[15:0];
				REG_CLK_HALF:     cfg_q.clk_half     <= cfg_data[15:0];
				REG_FRAME_PERIOD: cfg_q.frame_period <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/lsrs_step.sv
// Next-state and result logic for one tick of the readout sequencer.
`timescale 1ns / 1ps

module lsrs_step #(
	parameter int unsigned PIXELS  = 128,
	parameter int unsigned TICK_US = 10,
	parameter int unsigned PCW     = $clog2(PIXELS + 2)
) (
	input  lsrs_pkg::lsrs_state_t            st,
	input  logic [PCW-1:0]                   pulse_count,
	input  lsrs_pkg::lsrs_cfg_t              cfg,
	input  logic [lsrs_pkg::SAMPLE_W-1:0]    adc_sample,
	output lsrs_pkg::lsrs_state_t            st_nx,
	output logic [PCW-1:0]                   pulse_count_nx,
	output lsrs_pkg::lsrs_result_t           res
);
	import lsrs_pkg::*;

	localparam logic [PCW-1:0] PULSES = PCW'(PIXELS + 1);

	logic [31:0] now_inc;
	logic [31:0] since_start;

	always_comb begin
		st_nx          = st;
		pulse_count_nx = pulse_count;
		res            = '0;

		now_inc   = st.now_us + 32'(TICK_US);
		st_nx.now_us = now_inc;

		// Start pulse: raise at frame start, drop once si_width has elapsed.
		if (st.phase == PH_PENDING) begin
			st_nx.si_level   = 1'b1;
			st_nx.start_time = now_inc;
			st_nx.phase      = PH_RUN;
		end
		since_start = now_inc - st_nx.start_time;
		if (st_nx.phase == PH_RUN && since_start >= 32'(cfg.si_width)) begin
			st_nx.si_level = 1'b0;
		end

		// Sensor clock: the sample is taken at the end of each high half.
		if (pulse_count < PULSES) begin
			if (st.clk_high) begin
				st_nx.clk_level = 1'b1;
				if (now_inc - st.rise_time >= 32'(cfg.clk_half)) begin
					res.sample_valid = 1'b1;
					res.pixel_index  = INDEX_W'(pulse_count);
					res.pixel_value  = adc_sample;
					st_nx.clk_high   = 1'b0;
					st_nx.fall_time  = now_inc;
				end
			end else begin
				st_nx.clk_level = 1'b0;
				if (now_inc - st.fall_time >= 32'(cfg.clk_half)) begin
					st_nx.rise_time = now_inc;
					pulse_count_nx  = pulse_count + PCW'(1);
					st_nx.clk_high  = 1'b1;
				end
			end
		end
		if (pulse_count_nx >= PULSES) begin
			st_nx.clk_level = 1'b0;
			st_nx.phase     = PH_WAIT;
		end

		// Restart the frame once the period since the start pulse has run out.
		if (st_nx.phase == PH_WAIT && since_start >= cfg.frame_period) begin
			st_nx.now_us   = '0;
			pulse_count_nx = '0;
			st_nx.phase    = PH_PENDING;
		end

		res.si_out  = st_nx.si_level;
		res.clk_out = st_nx.clk_level;
	end

endmodule

### src/lsrs_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
`timescale 1ns / 1ps

module lsrs_out_reg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  lsrs_pkg::lsrs_result_t  res_in,
	input  logic                    out_stall,
	output logic                    out_valid,
	output lsrs_pkg::lsrs_result_t  res_out,
	output logic                    full_stalled
);
	import lsrs_pkg::*;

	logic         valid_q;
	lsrs_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid    = valid_q;
	assign res_out      = res_q;
	assign full_stalled = valid_q & out_stall;

endmodule

### src/lsrs_checker.sv
// Port-level checks for the readout sequencer and their binding to the top level.
`timescale 1ns / 1ps

module lsrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          clk_out,
	input logic                          sample_valid,
	input logic [lsrs_pkg::INDEX_W-1:0]  pixel_index,
	input logic [lsrs_pkg::SAMPLE_W-1:0] pixel_value
);
	import lsrs_pkg::*;

	// A held result must not be overwritten by a new tick.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("tick accepted while result is held");

	// Each accepted tick yields a result on the next cycle.
	a_one_result_per_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted tick produced no result");

	// A capture happens at the end of a high half, so the clock pin is high.
	a_capture_clock_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_valid |-> clk_out)
		else $error("sample captured with clock low");

	// Without a capture the index and value fields are zero.
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_valid |-> pixel_index == '0 && pixel_value == '0)
		else $error("pixel fields set without a capture");

	// Protocol: a stalled result stays valid.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

endmodule

bind line_sensor_readout_sequencer lsrs_checker u_lsrs_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the line sensor readout sequencer.
`timescale 1ns / 1ps

module testbench;

	import lsrs_pkg::*;

	localparam int unsigned PIXELS  = 128;
	localparam int unsigned TICK_US = 10;

	// Cycles without any transfer on either channel before the run is declared hung.
	localparam int unsigned HANG_LIMIT = 4000;

	// Tracks the frame timing of the sequencer and holds the readouts that the
	// accepted ticks are due to produce, oldest first.
	class readout_checker;
		logic [15:0]         si_width;
		logic [15:0]         clk_half;
		logic [31:0]         frame_period;
		logic [31:0]         now_us;
		lsrs_phase_t         phase;
		logic                clk_high;
		logic [8:0]          pulses;
		logic [31:0]         start_time;
		logic [31:0]         rise_time;
		logic [31:0]         fall_time;
		logic                si_level;
		logic                clk_level;
		lsrs_result_t        expected_readouts[$];
		int                  errors;

		function new();
			si_width     = SI_WIDTH_RST;
			clk_half     = CLK_HALF_RST;
			frame_period = FRAME_PERIOD_RST;
			now_us       = '0;
			phase        = PH_PENDING;
			clk_high     = 1'b1;
			pulses       = '0;
			start_time   = '0;
			rise_time    = '0;
			fall_time    = '0;
			si_level     = 1'b0;
			clk_level    = 1'b0;
			errors       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_SI_WIDTH:     si_width = data[15:0];
				REG_CLK_HALF:     clk_half = data[15:0];
				REG_FRAME_PERIOD: frame_period = data;
				default: ;
			endcase
		endfunction

		// Microseconds since a stored time, wrapping modulo 2^32.
		function logic [31:0] since(logic [31:0] t);
			return now_us - t;
		endfunction

		// One tick: advance the counter, then the start pulse, the clock and the restart.
		function void note_tick(logic [SAMPLE_W-1:0] sample);
			lsrs_result_t r;
			r = '0;
			now_us = now_us + TICK_US;

			if (phase == PH_PENDING) begin
				si_level   = 1'b1;
				start_time = now_us;
				phase      = PH_RUN;
			end
			if (phase == PH_RUN) begin
				if (since(start_time) >= {16'b0, si_width})
					si_level = 1'b0;
			end

			if (pulses < PIXELS + 1) begin
				if (clk_high) begin
					clk_level = 1'b1;
					if (since(rise_time) >= {16'b0, clk_half}) begin
						r.sample_valid = 1'b1;
						r.pixel_index  = pulses[7:0];
						r.pixel_value  = sample;
						clk_high       = 1'b0;
						fall_time      = now_us;
					end
				end else begin
					clk_level = 1'b0;
					if (since(fall_time) >= {16'b0, clk_half}) begin
						rise_time = now_us;
						pulses    = pulses + 1'b1;
						clk_high  = 1'b1;
					end
				end
			end
			if (pulses >= PIXELS + 1) begin
				clk_level = 1'b0;
				phase     = PH_WAIT;
			end

			if (phase == PH_WAIT) begin
				if (since(start_time) >= frame_period) begin
					now_us = '0;
					pulses = '0;
					phase  = PH_PENDING;
				end
			end

			r.si_out  = si_level;
			r.clk_out = clk_level;
			expected_readouts.push_back(r);
		endfunction

		function void check_result(lsrs_result_t got);
			lsrs_result_t want;
			if (expected_readouts.size() == 0) begin
				$error("readout with no tick waiting: si_out %0d clk_out %0d index %0d",
					got.si_out, got.clk_out, got.pixel_index);
				errors++;
				return;
			end
			want = expected_readouts.pop_front();
			if (got.si_out !== want.si_out) begin
				$error("si_out: expected %0d, got %0d", want.si_out, got.si_out);
				errors++;
			end
			if (got.clk_out !== want.clk_out) begin
				$error("clk_out: expected %0d, got %0d", want.clk_out, got.clk_out);
				errors++;
			end
			if (got.sample_valid !== want.sample_valid) begin
				$error("sample_valid: expected %0d, got %0d", want.sample_valid,
					got.sample_valid);
				errors++;
			end
			if (got.pixel_index !== want.pixel_index) begin
				$error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
				errors++;
			end
			if (got.pixel_value !== want.pixel_value) begin
				$error("pixel_value: expected %0d, got %0d", want.pixel_value, got.pixel_value);
				errors++;
			end
		endfunction

		function int pending();
			return expected_readouts.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_W-1:0]      cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   adc_sample = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic                  si_out;
	logic                  clk_out;
	logic                  sample_valid;
	logic [INDEX_W-1:0]    pixel_index;
	logic [SAMPLE_W-1:0]   pixel_value;

	readout_checker tracker = new();

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned idle_cycles    = 0;

	line_sensor_readout_sequencer #(
		.PIXELS (PIXELS),
		.TICK_US(TICK_US)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.adc_sample  (adc_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.si_out      (si_out),
		.clk_out     (clk_out),
		.sample_valid(sample_valid),
		.pixel_index (pixel_index),
		.pixel_value (pixel_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The receiver stalls at random, cycle by cycle, at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Both channels are sampled at the edge, before any of this edge's updates land.
	// A readout is checked before the tick of the same edge is noted, since a tick's
	// readout never leaves in the cycle the tick is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall === 1'b0)
				tracker.check_result('{si_out, clk_out, sample_valid, pixel_index,
					pixel_value});
			if (in_valid && in_stall === 1'b0)
				tracker.note_tick(adc_sample);
			if ((out_valid === 1'b1 && out_stall === 1'b0) ||
			    (in_valid && in_stall === 1'b0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// A hung handshake ends the run here.
	initial begin
		wait (idle_cycles >= HANG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offers one tick and returns at the edge where its transfer completes. The sender
	// may first hold back for a random number of cycles. Valid is only lowered when
	// the sender actually goes idle, so back-to-back ticks keep it high.
	task automatic send_tick(input logic [SAMPLE_W-1:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		adc_sample <= sample;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic send_random_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_tick(SAMPLE_W'($urandom_range(0, 4095)));
	endtask

	// Stops sending and waits until every readout has come back, plus a few cycles
	// so the block is quiet before anything else is done.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes all three timing registers on consecutive edges. The write enable stays
	// high across the three writes and drops once after the last one.
	task automatic set_timing(input logic [CFG_W-1:0] si_word, input logic [CFG_W-1:0] ch_word,
			input logic [CFG_W-1:0] fp_word);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SI_WIDTH;
		cfg_data  <= si_word;
		@(posedge clk);
		tracker.write_reg(REG_SI_WIDTH, si_word);
		cfg_index <= REG_CLK_HALF;
		cfg_data  <= ch_word;
		@(posedge clk);
		tracker.write_reg(REG_CLK_HALF, ch_word);
		cfg_index <= REG_FRAME_PERIOD;
		cfg_data  <= fp_word;
		@(posedge clk);
		tracker.write_reg(REG_FRAME_PERIOD, fp_word);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the reset timing the first capture comes on the fifth
		// tick; the samples swing between all zeros and all ones so both extremes
		// get captured.
		set_idling(0, 0);
		for (int i = 0; i < 16; i++)
			send_tick((i & 2) ? 12'hFFF : 12'h000);
		settle();

		// Zero durations: every interval ends on the first tick that checks it, so
		// the clock toggles each tick and a capture comes every other tick.
		set_timing(32'd0, 32'd0, 32'd0);
		for (int i = 0; i < 10; i++)
			send_tick((i & 2) ? 12'hFFF : 12'h000);
		settle();

		// Random part. Zero durations again, long enough to run through the dummy
		// pulse, all pixels and an immediate restart, where the clock times from
		// the old frame are stale.
		send_random_ticks(290);
		settle();

		// Short clock halves with a frame period shorter than the pulse train, so
		// each frame restarts as soon as the last pulse is done. Halfway through,
		// the sender waits until every readout has come back.
		set_timing(32'd40, 32'd10, 32'd2000);
		set_idling(55, 0);
		send_random_ticks(150);
		settle();
		send_random_ticks(150);
		settle();

		// Long start pulse: si_width outlasts the pulses, so SI stays high across
		// the restart. Junk in the upper halves of the 16-bit writes must be dropped.
		set_timing({16'($urandom()), 16'hFFFF}, {16'($urandom()), 16'h0000}, 32'd500);
		set_idling(0, 55);
		send_random_ticks(300);
		settle();

		// Random timing with light idling on both sides.
		set_timing(32'($urandom_range(0, 100)), 32'($urandom_range(0, 30)),
			32'($urandom_range(0, 4000)));
		set_idling(6, 6);
		send_random_ticks(70);
		settle();

		// Largest clock half and frame period.
		set_timing(32'd5, 32'h0000_FFFF, 32'hFFFF_FFFF);
		send_random_ticks(30);
		settle();

		// Back to short timing, this time with no idling at all.
		set_timing(32'($urandom_range(0, 50)), 32'd0, 32'($urandom_range(0, 3000)));
		set_idling(0, 0);
		send_random_ticks(40);
		settle();

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
